// ===== rtl/aoa_pkg.sv =====
// ----------------------------------------------------------------------------
// aoa_pkg
// shared types and constants of the oversampling averager: item formats,
// field widths, command codes and the controller-to-datapath command bundle
// ----------------------------------------------------------------------------
package aoa_pkg;

    localparam int CMD_W      = 1;
    localparam int CH_W       = 3;
    localparam int RAW_W      = 16;
    localparam int AVG_W      = 13;
    localparam int CNT_W      = 5;
    localparam int SUM_W      = 18;
    localparam int WORD_SHIFT = 3;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd17;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw_word;
    } in_item_t;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [CNT_W-1:0] samples_used;
    } out_item_t;

    typedef struct packed {
        logic sample_en;
        logic read_en;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

endpackage

// ===== rtl/aoa_divider.sv =====
// ----------------------------------------------------------------------------
// aoa_divider
// restoring bit-serial divider: channel sum over sample count, one quotient
// bit per step, SUM_W steps per division
// ----------------------------------------------------------------------------
module aoa_divider
(
    input  logic                       clk,
    input  logic                       start,
    input  logic                       step,
    input  logic [aoa_pkg::SUM_W-1:0]  dividend,
    input  logic [aoa_pkg::CNT_W-1:0]  divisor,
    output logic [aoa_pkg::SUM_W-1:0]  quotient
);

    logic [aoa_pkg::SUM_W-1:0] quot_reg;
    logic [aoa_pkg::SUM_W-1:0] quot_next;
    logic [aoa_pkg::CNT_W-1:0] rem_reg;
    logic [aoa_pkg::CNT_W-1:0] rem_next;
    logic [aoa_pkg::CNT_W-1:0] div_reg;
    logic [aoa_pkg::CNT_W:0]   partial;
    logic [aoa_pkg::CNT_W:0]   trial;
    logic                      fits;

    always_comb
    begin
        partial   = {rem_reg, quot_reg[aoa_pkg::SUM_W-1]};
        trial     = partial - {1'b0, div_reg};
        fits      = (partial >= {1'b0, div_reg});
        quot_next = {quot_reg[aoa_pkg::SUM_W-2:0], fits};
        rem_next  = fits ? trial[aoa_pkg::CNT_W-1:0] : partial[aoa_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient = quot_reg;

endmodule

// ===== rtl/aoa_datapath.sv =====
// ----------------------------------------------------------------------------
// aoa_datapath
// per-channel sum and count store, sample limit register, divider and the
// output register
// ----------------------------------------------------------------------------
module aoa_datapath
#(
    parameter int CHANNELS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  aoa_pkg::ctrl_cmd_t         ctrl,
    input  aoa_pkg::in_item_t          in_item,
    input  logic                       cfg_wr_en,
    input  logic [aoa_pkg::CNT_W-1:0]  cfg_wr_data,
    output aoa_pkg::out_item_t         out_item
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = aoa_pkg::CH_W + 2;

    logic [aoa_pkg::SUM_W-1:0] sums_reg   [CHANNELS];
    logic [aoa_pkg::CNT_W-1:0] counts_reg [CHANNELS];
    logic [aoa_pkg::CNT_W-1:0] limit_reg;
    logic [aoa_pkg::CNT_W-1:0] read_cnt_reg;
    aoa_pkg::out_item_t        out_item_reg;

    logic                      ch_ok;
    logic [IDX_W-1:0]          idx;
    logic [aoa_pkg::SUM_W-1:0] cur_sum;
    logic [aoa_pkg::CNT_W-1:0] cur_cnt;
    logic [aoa_pkg::SUM_W-1:0] base_sum;
    logic [aoa_pkg::CNT_W-1:0] base_cnt;
    logic [aoa_pkg::SUM_W-1:0] sum_next;
    logic [aoa_pkg::CNT_W-1:0] cnt_next;
    logic [aoa_pkg::SUM_W-1:0] div_dividend;
    logic [aoa_pkg::CNT_W-1:0] div_divisor;
    logic [aoa_pkg::SUM_W-1:0] quotient;

    always_comb
    begin
        ch_ok    = (CMP_W'(in_item.channel) < CMP_W'(CHANNELS));
        idx      = ch_ok ? IDX_W'(in_item.channel) : '0;
        cur_sum  = sums_reg[idx];
        cur_cnt  = counts_reg[idx];
        // restart the channel once the limit is reached
        base_sum = (cur_cnt >= limit_reg) ? '0 : cur_sum;
        base_cnt = (cur_cnt >= limit_reg) ? '0 : cur_cnt;
        sum_next = base_sum
                 + aoa_pkg::SUM_W'(in_item.raw_word >> aoa_pkg::WORD_SHIFT);
        cnt_next = base_cnt + aoa_pkg::CNT_W'(1);
        div_dividend = ch_ok ? cur_sum : '0;
        div_divisor  = ch_ok ? cur_cnt : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i]   <= '0;
                counts_reg[i] <= '0;
            end
            limit_reg <= aoa_pkg::LIMIT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (ctrl.sample_en && ch_ok)
            begin
                sums_reg[idx]   <= sum_next;
                counts_reg[idx] <= cnt_next;
            end
            else if (ctrl.read_en && ch_ok)
            begin
                sums_reg[idx]   <= '0;
                counts_reg[idx] <= '0;
            end
        end
    end

    aoa_divider u_divider
    (
        .clk      (clk),
        .start    (ctrl.read_en),
        .step     (ctrl.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.read_en)
        begin
            read_cnt_reg <= div_divisor;
        end
        if (ctrl.load_out)
        begin
            out_item_reg.average      <= (read_cnt_reg == '0) ? '0
                                       : quotient[aoa_pkg::AVG_W-1:0];
            out_item_reg.samples_used <= read_cnt_reg;
        end
    end

    assign out_item = out_item_reg;

endmodule

// ===== rtl/aoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// aoa_ctrl
// controller: takes transactions, sequences the divider steps on reads and
// hands finished results to the output register
// ----------------------------------------------------------------------------
module aoa_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [aoa_pkg::CMD_W-1:0]  in_cmd,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output aoa_pkg::ctrl_cmd_t         ctrl
);

    localparam int STEP_W = $clog2(aoa_pkg::SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(aoa_pkg::SUM_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        ctrl.sample_en = in_ready && in_valid && (in_cmd == aoa_pkg::CMD_SAMPLE);
        ctrl.read_en   = in_ready && in_valid && (in_cmd == aoa_pkg::CMD_READ);
        ctrl.div_step  = (state_reg == ST_DIVIDE);
        ctrl.load_out  = (state_reg == ST_DELIVER) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.read_en)
                    begin
                        state_reg <= ST_DIVIDE;
                        step_reg  <= '0;
                    end
                end
                ST_DIVIDE:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (ctrl.load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/adc_oversample_averager.sv =====
// ----------------------------------------------------------------------------
// adc_oversample_averager
// multi-channel oversampling averager: sample transactions accumulate the
// converter word shifted right by three per channel; read transactions return
// the truncated average with its sample count and clear the channel
//
// input channel: in_valid / in_ready with in_item (cmd, channel, raw_word)
// output channel: out_valid / out_ready with out_item (average, samples_used)
// config: cfg_wr_en / cfg_wr_data write sample_limit, no wait, no read-back
// a sample transaction produces no result and leaves in_ready high; the next
//   transaction may follow in the very next cycle
// a read transaction runs the bit-serial divider, one quotient bit per cycle,
//   then loads the output register once that is free; out_valid rises and
//   in_ready returns at the same edge
// a finished result waits in the output register; while it waits further
//   transactions are taken, and a second read holds its result and keeps
//   in_ready low until the receiver takes the first
// reset clears every channel's sum and count, sets sample_limit to 17 and
//   drops out_valid
// ----------------------------------------------------------------------------
module adc_oversample_averager
#(
    parameter int CHANNELS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  aoa_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output aoa_pkg::out_item_t         out_item,
    input  logic                       cfg_wr_en,
    input  logic [aoa_pkg::CNT_W-1:0]  cfg_wr_data
);

    aoa_pkg::ctrl_cmd_t ctrl;

    aoa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_item.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    aoa_datapath
    #(
        .CHANNELS (CHANNELS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_item    (out_item)
    );

endmodule

// ===== tb/tb_adc_oversample_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_oversample_averager
// self-checking bench for the oversampling averager: a queue-fed driver offers
// sample and read transactions, a channel tracker predicts each read's average
// and count, and the result checker compares them field by field; the sample
// limit is rewritten between phases, both sides idle at random and the
// receiver once holds off long enough to stall the input
// ----------------------------------------------------------------------------
module tb_adc_oversample_averager;

    localparam int NUM_CH       = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_WAIT  = 25;
    localparam int PHASE_ITEMS  = 140;
    localparam int STALL_CYCLES = 300;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    aoa_pkg::in_item_t          in_item     = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    aoa_pkg::out_item_t         out_item;
    logic                       cfg_wr_en   = 1'b0;
    logic [aoa_pkg::CNT_W-1:0]  cfg_wr_data = '0;

    aoa_pkg::in_item_t          item_backlog[$];
    aoa_pkg::out_item_t         expected_averages[$];

    logic [aoa_pkg::SUM_W-1:0]  ch_sum   [NUM_CH] = '{default: '0};
    logic [aoa_pkg::CNT_W-1:0]  ch_count [NUM_CH] = '{default: '0};
    logic [aoa_pkg::CNT_W-1:0]  limit_shadow      = aoa_pkg::LIMIT_RESET;

    int unsigned       items_offered = 0;
    int unsigned       items_taken   = 0;
    int unsigned       averages_seen = 0;
    int unsigned       mismatches    = 0;
    int unsigned       idle_cycles   = 0;
    int unsigned       stall_left    = 0;
    bit                stall_done    = 1'b0;
    bit                no_gaps       = 1'b0;

    adc_oversample_averager #(
        .CHANNELS (NUM_CH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // input driver
    always @(negedge clk)
    begin : item_driver
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (!in_valid || items_taken == items_offered)
            begin
                next_valid = 1'b0;
                if (item_backlog.size() > 0 && (no_gaps || $urandom_range(99) >= 11))
                begin
                    in_item <= item_backlog.pop_front();
                    items_offered++;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // receiver, with one long hold-off
    always @(negedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (!stall_done && averages_seen >= 20)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_gaps || ($urandom_range(99) >= 11);
        end
    end

    // per-channel accumulation on each accepted transaction
    always @(posedge clk)
    begin : channel_tracker
        aoa_pkg::out_item_t avg_res;
        if (rst_n && in_valid && in_ready)
        begin
            items_taken++;
            if (in_item.cmd == aoa_pkg::CMD_SAMPLE)
            begin
                if (in_item.channel < NUM_CH)
                begin
                    if (ch_count[in_item.channel] >= limit_shadow)
                    begin
                        ch_sum[in_item.channel]   = '0;
                        ch_count[in_item.channel] = '0;
                    end
                    ch_sum[in_item.channel] =
                        ch_sum[in_item.channel]
                        + aoa_pkg::SUM_W'(in_item.raw_word >> aoa_pkg::WORD_SHIFT);
                    ch_count[in_item.channel] = ch_count[in_item.channel] + 1'b1;
                end
            end
            else
            begin
                avg_res = '0;
                if (in_item.channel < NUM_CH)
                begin
                    avg_res.samples_used = ch_count[in_item.channel];
                    if (ch_count[in_item.channel] != 0)
                        avg_res.average = aoa_pkg::AVG_W'(ch_sum[in_item.channel]
                                                          / ch_count[in_item.channel]);
                    ch_sum[in_item.channel]   = '0;
                    ch_count[in_item.channel] = '0;
                end
                expected_averages.push_back(avg_res);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        aoa_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            averages_seen++;
            if (expected_averages.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: avg=%0d n=%0d",
                             out_item.average, out_item.samples_used);
            end
            else
            begin
                want = expected_averages.pop_front();
                if (out_item.average !== want.average
                    || out_item.samples_used !== want.samples_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected avg=%0d n=%0d, got avg=%0d n=%0d",
                                 averages_seen, want.average, want.samples_used,
                                 out_item.average, out_item.samples_used);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("adc_oversample_averager: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [aoa_pkg::CMD_W-1:0] cmd, input int unsigned ch,
                              input int unsigned raw);
        aoa_pkg::in_item_t it;
        it.cmd      = cmd;
        it.channel  = aoa_pkg::CH_W'(ch);
        it.raw_word = aoa_pkg::RAW_W'(raw);
        item_backlog.push_back(it);
    endtask

    // wait until every transaction is taken and every average has come back
    task automatic settle();
        while (item_backlog.size() != 0 || items_taken != items_offered
               || expected_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= aoa_pkg::CNT_W'(value);
        limit_shadow = aoa_pkg::CNT_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned lim_plan [8];
        int unsigned read_pct;
        int unsigned ch_mask;
        int unsigned ch_flip;
        int unsigned raw;
        lim_plan    = '{31, 0, 12, 1, 31, 4, 0, 31};
        lim_plan[5] = $urandom_range(30, 2);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limit: empty read, rounding, full scale, read ignores raw word
        queue_item(aoa_pkg::CMD_READ,   0, 16'h0000);
        queue_item(aoa_pkg::CMD_SAMPLE, 0, 16'hFFFF);
        queue_item(aoa_pkg::CMD_SAMPLE, 0, 16'h0000);
        queue_item(aoa_pkg::CMD_SAMPLE, 0, 16'h0007);
        queue_item(aoa_pkg::CMD_READ,   0, 16'h0000);
        queue_item(aoa_pkg::CMD_SAMPLE, 7, 16'hFFF8);
        queue_item(aoa_pkg::CMD_READ,   7, 16'hFFFF);
        queue_item(aoa_pkg::CMD_SAMPLE, 5, 16'h8000);
        queue_item(aoa_pkg::CMD_SAMPLE, 5, 16'h8000);
        queue_item(aoa_pkg::CMD_SAMPLE, 5, 16'h8000);
        queue_item(aoa_pkg::CMD_READ,   3, 16'hA5A5);
        settle();

        // limit zero, with channel 5 already above it
        write_limit(0);
        queue_item(aoa_pkg::CMD_SAMPLE, 5, 16'h1238);
        queue_item(aoa_pkg::CMD_SAMPLE, 2, 16'hFFFF);
        queue_item(aoa_pkg::CMD_SAMPLE, 2, 16'h1238);
        queue_item(aoa_pkg::CMD_READ,   2, 16'h0000);
        queue_item(aoa_pkg::CMD_READ,   5, 16'h5A5A);
        settle();

        write_limit(1);
        queue_item(aoa_pkg::CMD_SAMPLE, 4, 16'h4000);
        queue_item(aoa_pkg::CMD_SAMPLE, 4, 16'h2000);
        queue_item(aoa_pkg::CMD_READ,   4, 16'h0000);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_limit(lim_plan[ph]);
            no_gaps  = (ph == 4);
            read_pct = $urandom_range(15, 2);
            case ($urandom_range(2))
                0:       ch_mask = 0;
                1:       ch_mask = 1;
                default: ch_mask = 7;
            endcase
            ch_flip = $urandom_range(7);
            repeat (PHASE_ITEMS)
            begin
                case ($urandom_range(7))
                    0:       raw = 16'hFFFF;
                    1:       raw = 16'h0000;
                    2:       raw = $urandom_range(7);
                    default: raw = $urandom_range(65535);
                endcase
                queue_item(($urandom_range(99) < read_pct) ? aoa_pkg::CMD_READ
                                                           : aoa_pkg::CMD_SAMPLE,
                           ($urandom_range(7) & ch_mask) ^ ch_flip, raw);
            end
            settle();
        end
        no_gaps = 1'b0;

        if (mismatches == 0)
            $display("adc_oversample_averager: match");
        else
            $display("adc_oversample_averager: mismatch");
        $finish;
    end

endmodule
